FILE: rtl/dpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dpq_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_DITHER_MODE = 2'd0;
    localparam logic [1:0] REG_CLIP_ENABLE = 2'd1;
    localparam logic [1:0] REG_NOISE_SEED  = 2'd2;

    // Dither mode codes; the unused code behaves as no dither.
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_RECT = 2'd1;
    localparam logic [1:0] MODE_TRI  = 2'd2;

    localparam logic [1:0]  DITHER_MODE_RESET = MODE_TRI;
    localparam logic        CLIP_RESET        = 1'b1;
    localparam logic [31:0] RNG_RESET         = 32'd1;

    // Linear congruential generator constants.
    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;

    // Plus one in Q4.28.
    localparam logic signed [31:0] ONE_Q28 = 32'sd268435456;

    // Noise offsets in Q31 units, applied when the sample is loaded.
    localparam logic signed [35:0] OFS_TPDF = -36'sd65535;
    localparam logic signed [35:0] OFS_RPDF = -36'sd32768;

    localparam logic signed [19:0] PCM_MAX = 20'sd32767;
    localparam logic signed [19:0] PCM_MIN = -20'sd32768;

    typedef struct packed {
        logic load;
        logic rng_step;
        logic add_r;
        logic scale;
        logic round;
    } t_cmd;

    typedef struct packed {
        logic tpdf;
        logic rpdf;
    } t_status;

endpackage

`default_nettype wire

FILE: rtl/dithered_pcm16_quantizer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Requantizes one signed Q4.28 sample per beat to saturated 16-bit PCM, with optional
// clamping to plus or minus one and rectangular or triangular dither from a 32-bit LCG.
// After the load, triangular dither takes two noise draws and rectangular dither one, each
// a single LCG step with its 32-bit multiply; a summing step follows the last draw, then
// a scaling step and a rounding step. Without dither the load goes straight to scaling.
// The input is stalled until the result is written. The next sample is accepted as soon
// as the previous result sits in the output register; a stalled output holds only the
// following result back, which then waits in its rounding step.
// Writing noise_seed reloads the generator; write configuration only while idle.
module dithered_pcm16_quantizer_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [31:0] i_sample_in,
    input  wire logic               i_last_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [15:0]      o_pcm_out,
    output logic                    o_last_out
);
    import dpq_pkg::*;

    t_cmd    cmd;
    t_status status;

    dpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    dpq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample_in (i_sample_in),
        .i_last_in   (i_last_in),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_pcm_out   (o_pcm_out),
        .o_last_out  (o_last_out)
    );

endmodule

`default_nettype wire

FILE: rtl/dpq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dpq_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    input  wire dpq_pkg::t_status i_status,
    output dpq_pkg::t_cmd         o_cmd
);
    import dpq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DRAW1 = 3'd1;
    localparam logic [2:0] S_DRAW2 = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_ROUND = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = (i_status.tpdf || i_status.rpdf) ? S_DRAW1 : S_SCALE;
                end
            end
            S_DRAW1: begin
                cmd.rng_step = 1'b1;
                n_state      = i_status.tpdf ? S_DRAW2 : S_ADD;
            end
            S_DRAW2: begin
                // The first draw is summed while the second one is generated.
                cmd.rng_step = 1'b1;
                cmd.add_r    = 1'b1;
                n_state      = S_ADD;
            end
            S_ADD: begin
                cmd.add_r = 1'b1;
                n_state   = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale = 1'b1;
                n_state   = S_ROUND;
            end
            S_ROUND: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.round = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.round) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // A finished beat must never overwrite one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.round && r_out_valid && i_out_stall))
        else $error("result written over a stalled beat");

    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> o_in_stall)
        else $error("input not stalled after accepting a beat");

    a_valid_after_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.round |=> r_out_valid)
        else $error("result not presented after rounding");

    a_scale_then_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCALE) |=> (r_state == S_ROUND))
        else $error("scale not followed by round");

endmodule

`default_nettype wire

FILE: rtl/dpq_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module dpq_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic signed [31:0] i_sample_in,
    input  wire logic               i_last_in,
    input  wire dpq_pkg::t_cmd      i_cmd,
    output dpq_pkg::t_status        o_status,
    output logic signed [15:0]      o_pcm_out,
    output logic                    o_last_out
);
    import dpq_pkg::*;

    logic [1:0]         r_mode;
    logic               r_clip;
    logic [31:0]        r_rng;
    logic [31:0]        n_rng;
    logic signed [35:0] r_s;
    logic signed [35:0] n_s;
    logic signed [50:0] r_p;
    logic               r_last;
    logic signed [15:0] r_pcm;
    logic               r_last_out;

    logic signed [31:0] x_clamped;
    logic signed [35:0] x_ext;
    logic signed [35:0] ofs;
    logic signed [50:0] n_p;
    logic signed [19:0] q_floor;
    logic signed [19:0] q;
    logic signed [15:0] q_sat;
    logic               round_up;

    // Configuration and noise generator state.
    always_comb begin
        n_rng = r_rng * LCG_MUL + LCG_ADD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= DITHER_MODE_RESET;
            r_clip <= CLIP_RESET;
            r_rng  <= RNG_RESET;
        end else begin
            if (i_cfg_we && i_cfg_index == REG_DITHER_MODE) begin
                r_mode <= i_cfg_data[1:0];
            end
            if (i_cfg_we && i_cfg_index == REG_CLIP_ENABLE) begin
                r_clip <= i_cfg_data[0];
            end
            if (i_cfg_we && i_cfg_index == REG_NOISE_SEED) begin
                r_rng <= i_cfg_data;
            end else if (i_cmd.rng_step) begin
                r_rng <= n_rng;
            end
        end
    end

    assign o_status.tpdf = (r_mode == MODE_TRI);
    assign o_status.rpdf = (r_mode == MODE_RECT);

    // Load: clamp if enabled, move to Q31 and pre-apply the noise offset; else add a draw.
    always_comb begin
        x_clamped = i_sample_in;
        if (r_clip) begin
            if (i_sample_in > ONE_Q28) begin
                x_clamped = ONE_Q28;
            end else if (i_sample_in < -ONE_Q28) begin
                x_clamped = -ONE_Q28;
            end
        end
        x_ext = 36'(x_clamped);
        priority if (o_status.tpdf) begin
            ofs = OFS_TPDF;
        end else if (o_status.rpdf) begin
            ofs = OFS_RPDF;
        end else begin
            ofs = '0;
        end
        if (i_cmd.load) begin
            n_s = (x_ext <<< 3) + ofs;
        end else begin
            n_s = r_s + $signed({20'd0, r_rng[31:16]});
        end
    end

    // Multiplying by 32767 is a shift by 15 less the value itself.
    assign n_p = $signed({r_s, 15'd0}) - $signed({{15{r_s[35]}}, r_s});

    // Truncation toward zero: floor, then step up for a negative value with a fraction.
    always_comb begin
        q_floor  = r_p[50:31];
        round_up = r_p[50] && (|r_p[30:0]);
        q        = q_floor + $signed({19'd0, round_up});
        priority if (q > PCM_MAX) begin
            q_sat = 16'(PCM_MAX);
        end else if (q < PCM_MIN) begin
            q_sat = 16'(PCM_MIN);
        end else begin
            q_sat = q[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.add_r) begin
            r_s <= n_s;
        end
        if (i_cmd.load) begin
            r_last <= i_last_in;
        end
        if (i_cmd.scale) begin
            r_p <= n_p;
        end
        if (i_cmd.round) begin
            r_pcm      <= q_sat;
            r_last_out <= r_last;
        end
    end

    assign o_pcm_out  = r_pcm;
    assign o_last_out = r_last_out;

endmodule

`default_nettype wire

FILE: tb/sv/tb_dithered_pcm16_quantizer_unit.sv
`timescale 1ns / 1ps

module tb_dithered_pcm16_quantizer_unit;
    import dpq_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 1350;

    localparam logic [1:0] REG_UNUSED    = 2'd3;
    localparam logic [1:0] DITHER_UNUSED = 2'd3;

    typedef struct {
        logic signed [15:0] pcm;
        logic               last;
    } t_pcm_beat;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [31:0] i_sample_in;
    logic               i_last_in;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [15:0] o_pcm_out;
    logic               o_last_out;

    // Predictor state, kept in step with every register write and accepted beat.
    logic [1:0]  cfg_mode;
    logic        cfg_clip;
    logic [31:0] lcg_state;

    t_pcm_beat expected_pcm[$];
    int        errors      = 0;
    int        cycle_count = 0;
    int        hold_cycles = 0;
    int        stall_left  = 0;
    bit        idle_on     = 1'b1;

    dithered_pcm16_quantizer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample_in (i_sample_in),
        .i_last_in   (i_last_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pcm_out   (o_pcm_out),
        .o_last_out  (o_last_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL dithered_pcm16_quantizer_unit");
            $finish;
        end
    end

    function automatic logic [15:0] lcg_draw();
        lcg_state = lcg_state * LCG_MUL + LCG_ADD;
        return lcg_state[31:16];
    endfunction

    function automatic logic signed [15:0] quantize_sample(input logic signed [31:0] q28_in);
        longint x;
        longint acc;
        longint r1;
        longint r2;
        longint prod;
        longint q;
        x = longint'(q28_in);
        if (cfg_clip) begin
            if (x > longint'(ONE_Q28))
                x = longint'(ONE_Q28);
            else if (x < -longint'(ONE_Q28))
                x = -longint'(ONE_Q28);
        end
        // Move to Q31 so that the noise lands in whole units.
        acc = x * 8;
        case (cfg_mode)
            MODE_TRI: begin
                r1 = longint'(lcg_draw());
                r2 = longint'(lcg_draw());
                acc = acc + r1 + r2 - 65535;
            end
            MODE_RECT: begin
                r1 = longint'(lcg_draw());
                acc = acc + r1 - 32768;
            end
            default: ;
        endcase
        prod = acc * 32767;
        // Truncation is toward zero, so negative products shift their magnitude.
        if (prod < 0)
            q = -((-prod) >>> 31);
        else
            q = prod >>> 31;
        if (q > longint'(PCM_MAX))
            q = longint'(PCM_MAX);
        else if (q < longint'(PCM_MIN))
            q = longint'(PCM_MIN);
        return q[15:0];
    endfunction

    // Result check and output stall pattern share one process so the stall seen
    // at an edge is the one the block saw.
    always @(posedge i_clk) begin : check_results
        t_pcm_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pcm.size() == 0) begin
                $display("%0t: unexpected beat, pcm_out %0d last_out %0b",
                         $time, o_pcm_out, o_last_out);
                errors++;
            end else begin
                want = expected_pcm.pop_front();
                if (o_pcm_out !== want.pcm) begin
                    $display("%0t: pcm_out mismatch, expected %0d, actual %0d",
                             $time, want.pcm, o_pcm_out);
                    errors++;
                end
                if (o_last_out !== want.last) begin
                    $display("%0t: last_out mismatch, expected %0b, actual %0b",
                             $time, want.last, o_last_out);
                    errors++;
                end
            end
        end
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles--;
        end else if (!idle_on) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else begin
            stall_left = $urandom_range(0, 15);
            i_out_stall <= ($urandom_range(0, 1) == 0);
        end
    end

    task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (index)
            REG_DITHER_MODE: cfg_mode = data[1:0];
            REG_CLIP_ENABLE: cfg_clip = data[0];
            REG_NOISE_SEED:  lcg_state = data;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_sample(input logic signed [31:0] q28_in, input logic last);
        t_pcm_beat beat;
        i_in_valid  <= 1'b1;
        i_sample_in <= q28_in;
        i_last_in   <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        beat.pcm  = quantize_sample(q28_in);
        beat.last = last;
        expected_pcm.push_back(beat);
        if (idle_on && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_pcm.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] random_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $signed($urandom_range(0, 32'h2010_0000)) - 32'sh1008_0000;
            // Near zero, where the dither decides the output code.
            4: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            5: return ($urandom_range(0, 1) ? ONE_Q28 : -ONE_Q28)
                      + $signed($urandom_range(0, 128)) - 32'sd64;
            6: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    task automatic random_config();
        logic [1:0] mode;
        mode = 2'($urandom_range(0, 3));
        write_reg(REG_DITHER_MODE, ($urandom() & 32'hFFFF_FFFC) | {30'd0, mode});
        write_reg(REG_CLIP_ENABLE, ($urandom() & 32'hFFFF_FFFE) | $urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: write_reg(REG_NOISE_SEED, 32'h0000_0000);
            1: write_reg(REG_NOISE_SEED, 32'hFFFF_FFFF);
            2: write_reg(REG_NOISE_SEED, $urandom());
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, $urandom());
    endtask

    task automatic test_reset_state();
        send_sample(32'sd0, 1'b0);
        send_sample(ONE_Q28, 1'b1);
        send_sample(-ONE_Q28, 1'b0);
    endtask

    task automatic test_dither_modes();
        wait_idle();
        write_reg(REG_DITHER_MODE, {30'd0, MODE_OFF});
        send_sample(32'sh0800_0000, 1'b1);
        send_sample(-32'sh0000_1FFF, 1'b0);
        wait_idle();
        write_reg(REG_DITHER_MODE, {30'd0, MODE_RECT});
        send_sample(32'sd0, 1'b0);
        send_sample(32'sh0000_2000, 1'b1);
        wait_idle();
        // The unused code must neither add noise nor advance the generator.
        write_reg(REG_DITHER_MODE, {30'd0, DITHER_UNUSED});
        send_sample(32'sd4096, 1'b0);
        send_sample(-32'sd4096, 1'b1);
    endtask

    task automatic test_clipping();
        wait_idle();
        write_reg(REG_DITHER_MODE, {30'd0, MODE_OFF});
        write_reg(REG_CLIP_ENABLE, 32'd1);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh8000_0000, 1'b1);
        send_sample(ONE_Q28 + 32'sd1, 1'b0);
        wait_idle();
        write_reg(REG_CLIP_ENABLE, 32'd0);
        send_sample(32'sh7FFF_FFFF, 1'b1);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(ONE_Q28, 1'b1);
        send_sample(-ONE_Q28 - 32'sd1, 1'b0);
        send_sample(-32'sd1, 1'b1);
    endtask

    task automatic test_seed_reload();
        wait_idle();
        write_reg(REG_DITHER_MODE, {30'd0, MODE_RECT});
        write_reg(REG_NOISE_SEED, 32'h0000_0000);
        send_sample(32'sd0, 1'b0);
        send_sample(32'sd0, 1'b1);
        wait_idle();
        write_reg(REG_DITHER_MODE, {30'd0, MODE_TRI});
        write_reg(REG_NOISE_SEED, 32'hFFFF_FFFF);
        send_sample(ONE_Q28, 1'b0);
        send_sample(-ONE_Q28, 1'b1);
        wait_idle();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_sample(32'sd12345, 1'b0);
    endtask

    task automatic test_random_phases();
        int sent;
        int count;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            random_config();
            idle_on = ($urandom_range(0, 3) != 0);
            count = $urandom_range(60, 140);
            repeat (count) send_sample(random_sample(), 1'($urandom_range(0, 1)));
            sent += count;
        end
        idle_on = 1'b1;
    endtask

    // The receiver holds off long enough that the block fills and stalls its input.
    task automatic test_output_backpressure();
        idle_on     = 1'b0;
        hold_cycles = 200;
        repeat (30) send_sample(random_sample(), 1'($urandom_range(0, 1)));
        idle_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (20) send_sample(random_sample(), 1'($urandom_range(0, 1)));
        wait_idle();
        repeat (20) send_sample(random_sample(), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_streaming();
        wait_idle();
        random_config();
        idle_on = 1'b0;
        repeat (150) send_sample(random_sample(), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_DITHER_MODE;
        i_cfg_data  <= 32'd0;
        i_in_valid  <= 1'b0;
        i_sample_in <= 32'sd0;
        i_last_in   <= 1'b0;
        i_out_stall <= 1'b0;
        cfg_mode  = DITHER_MODE_RESET;
        cfg_clip  = CLIP_RESET;
        lcg_state = RNG_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_dither_modes();
        test_clipping();
        test_seed_reload();
        test_random_phases();
        test_output_backpressure();
        test_drain_pause();
        test_streaming();
        wait_idle();

        if (errors == 0)
            $display("PASS dithered_pcm16_quantizer_unit");
        else
            $display("FAIL dithered_pcm16_quantizer_unit");
        $finish;
    end

endmodule
